// ----- sv/rita_pkg.sv -----
// Shared types, widths and the digit character table of the radix converter.
package rita_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int RADIX_W            = 5;
   localparam int DIGIT_W            = 4;
   localparam int CHAR_W             = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

   localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };

   typedef struct packed {
      logic               done;
      logic               more;
      logic [DIGIT_W-1:0] digit;
   } div_status_type;

endpackage

// ----- sv/rita_div_serial.sv -----
// Bit-serial restoring divider that peels off one base-radix digit per pass.
module rita_div_serial
   import rita_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [VALUE_BITS-1:0] load_value,
   input  logic [RADIX_W-1:0]    load_radix,
   output div_status_type        status
);

   localparam int BIT_W = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic                  busy_ff, busy_in;
   logic                  any_ff, any_in;

   logic [RADIX_W-1:0] rem_sh;
   logic [RADIX_W-1:0] diff;
   logic               ge;
   logic [DIGIT_W-1:0] rem_step;
   logic               last_step;

   always_comb begin
      rem_sh    = {rem_ff, quo_ff[VALUE_BITS-1]};
      ge        = (rem_sh >= radix_ff);
      diff      = rem_sh - radix_ff;
      rem_step  = ge ? diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
      last_step = busy_ff && (bit_ff == BIT_W'(VALUE_BITS - 1));

      status.done  = last_step;
      status.more  = any_ff | ge;
      status.digit = rem_step;
   end

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      bit_in   = bit_ff;
      busy_in  = busy_ff;
      any_in   = any_ff;
      if (load) begin
         quo_in  = load_value;
         rem_in  = '0;
         bit_in  = '0;
         any_in  = 1'b0;
         busy_in = 1'b1;
         if (load_radix < RADIX_MIN) begin
            radix_in = RADIX_MIN;
         end else if (load_radix > RADIX_MAX) begin
            radix_in = RADIX_MAX;
         end else begin
            radix_in = load_radix;
         end
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], ge};
         if (last_step) begin
            // The quotient now sits in place and, if it is nonzero, the next pass divides it again.
            rem_in  = '0;
            bit_in  = '0;
            any_in  = 1'b0;
            busy_in = any_ff | ge;
         end else begin
            rem_in = rem_step;
            bit_in = bit_ff + BIT_W'(1);
            any_in = any_ff | ge;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         bit_ff  <= bit_in;
      end
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      any_ff   <= any_in;
   end

endmodule

// ----- sv/radix_integer_to_ascii_core.sv -----
// Top level of the radix integer to ASCII converter.
// Each request beat carries an unsigned value and a radix (values below 2 act as 2,
// above 16 as 16). The block answers with one response beat per digit, uppercase
// ASCII, most significant first, no leading zeros, and rsp_last on the final one;
// zero gives the single character '0'. Requests are taken one at a time. Each digit
// comes from a full pass of the bit-serial divider, which yields one quotient bit per
// cycle; each character then goes through the digit buffer read and the response
// register before it is shown.
module radix_integer_to_ascii_core
   import rita_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [RADIX_W-1:0]    req_radix,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_W-1:0]     rsp_digit_char,
   output logic                  rsp_last
);

   localparam int AW = $clog2(VALUE_BITS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_SHOW = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [AW-1:0]      count_ff, count_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [DIGIT_W-1:0] rd_ff;
   logic [DIGIT_W-1:0] digit_mem [VALUE_BITS];

   logic           div_load;
   div_status_type div_status;

   rita_div_serial #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .load      (div_load),
      .load_value(req_value),
      .load_radix(req_radix),
      .status    (div_status)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign div_load       = req_valid && req_ready;
   assign rsp_valid      = (state_ff == S_SHOW);
   assign rsp_digit_char = DIGIT_CHARS[rd_ff];
   assign rsp_last       = (idx_ff == '0);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (div_load) begin
               count_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               if (div_status.more) begin
                  count_in = count_ff + AW'(1);
               end else begin
                  idx_in   = count_ff;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_SHOW;
         end
         S_SHOW: begin
            if (rsp_ready) begin
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff - AW'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DIV && div_status.done) begin
         digit_mem[count_ff] <= div_status.digit;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_ff <= digit_mem[idx_ff];
      end
   end

endmodule

// ----- sv/rita_checker.sv -----
// Port-level assertions for the radix converter and their bind to the top level.
module rita_checker
   import rita_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_digit_char,
   input logic              rsp_last
);

   // A stalled response beat keeps its character and flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // No new request is taken while a conversion is still delivering characters.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted during a response run");

   // Every character is a decimal digit or an uppercase hex letter.
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_char >= 7'h30 && rsp_digit_char <= 7'h39) ||
                     (rsp_digit_char >= 7'h41 && rsp_digit_char <= 7'h46)))
      else $error("character outside the digit set");

   // The block is ready for a new value right after the final beat of a run.
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("not ready after the final character");

endmodule

bind radix_integer_to_ascii_core rita_checker u_rita_checker (.*);

// ----- dv/radix_ascii_digit_checker.sv -----
// Checker that predicts the digit beats of each accepted request and compares the responses.
module radix_ascii_digit_checker
   import rita_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [RADIX_W-1:0]    req_radix,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [CHAR_W-1:0]     rsp_digit_char,
   input  logic                  rsp_last,
   output int                    mismatch_count,
   output int                    beats_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CHAR_W-1:0] ASCII_ZERO     = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_LETTER_A = 7'h41;
   localparam int                REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_beat_type;

   digit_beat_type digits_due[$];
   int             failures = 0;

   function automatic void queue_digits(input logic [VALUE_BITS-1:0] value,
                                        input logic [RADIX_W-1:0]    radix);
      logic [VALUE_BITS-1:0] rest;
      int unsigned           base;
      logic [DIGIT_W-1:0]    digit;
      logic [CHAR_W-1:0]     low_first[$];
      digit_beat_type        beat;
      rest = value;
      if (radix < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         base = RADIX_MAX;
      end else begin
         base = radix;
      end
      if (rest == '0) begin
         low_first.push_back(ASCII_ZERO);
      end
      while (rest != '0) begin
         digit = DIGIT_W'(rest % base);
         if (digit < 10) begin
            low_first.push_back(ASCII_ZERO + CHAR_W'(digit));
         end else begin
            low_first.push_back(ASCII_LETTER_A + CHAR_W'(digit) - CHAR_W'(10));
         end
         rest = rest / base;
      end
      for (int k = low_first.size() - 1; k >= 0; k--) begin
         beat.digit_char = low_first[k];
         beat.last       = (k == 0);
         digits_due.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin : watch
      digit_beat_type due;
      if (!reset) begin
         if (req_valid && req_ready) begin
            queue_digits(req_value, req_radix);
         end
         if (rsp_valid && rsp_ready) begin
            if (digits_due.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("%0t: digit beat with nothing expected: char %h last %b",
                           $realtime, rsp_digit_char, rsp_last);
               end
            end else begin
               due = digits_due.pop_front();
               if (rsp_digit_char !== due.digit_char || rsp_last !== due.last) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display({"%0t: digit beat mismatch: expected char %h last %b, ",
                               "got char %h last %b"},
                              $realtime, due.digit_char, due.last, rsp_digit_char,
                              rsp_last);
                  end
               end
            end
         end
      end
      mismatch_count <= failures;
      beats_pending  <= digits_due.size();
   end

endmodule

// ----- dv/tb_radix_integer_to_ascii_core.sv -----
// Testbench top that drives conversion requests and response back-pressure and gives the verdict.
module tb_radix_integer_to_ascii_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rita_pkg::*;

   localparam int VALUE_BITS      = VALUE_BITS_DEFAULT;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int SETTLE_CYCLES   = 2 * (VALUE_BITS + 2);

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic [RADIX_W-1:0]    req_radix = RADIX_MIN;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHAR_W-1:0]     rsp_digit_char;
   logic                  rsp_last;

   int mismatch_count;
   int beats_pending;
   bit send_gaps     = 1'b0;
   bit sink_gaps     = 1'b0;
   int hold_off_asks = 0;

   always #2 clock = ~clock;

   radix_integer_to_ascii_core #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last      (rsp_last)
   );

   radix_ascii_digit_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) digit_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last      (rsp_last),
      .mismatch_count(mismatch_count),
      .beats_pending (beats_pending)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [RADIX_W-1:0] pick_radix();
      if ($urandom_range(9) < 8) return RADIX_W'($urandom_range(16, 2));
      if ($urandom_range(1) == 0) return RADIX_W'($urandom_range(1));
      return RADIX_W'($urandom_range(31, 17));
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value(input logic [RADIX_W-1:0] radix);
      logic [VALUE_BITS-1:0] full;
      longint unsigned       power;
      int unsigned           base;
      int                    steps;
      full = VALUE_BITS'({$urandom(), $urandom()});
      base = (radix < RADIX_MIN) ? RADIX_MIN : (radix > RADIX_MAX) ? RADIX_MAX : radix;
      power = 1;
      case ($urandom_range(6))
         0, 1: return full;
         2: return full >> $urandom_range(VALUE_BITS - 1);
         3: return VALUE_BITS'($urandom_range(base * base));
         4: begin
            steps = $urandom_range(VALUE_BITS - 1, 1);
            repeat (steps) begin
               if (((power * base) >> VALUE_BITS) == 0) power = power * base;
            end
            return VALUE_BITS'(power + $urandom_range(2) - 1);
         end
         5: return ($urandom_range(1) == 0) ? '0 : '1;
         default: return full >> $urandom_range(VALUE_BITS / 2, VALUE_BITS / 4);
      endcase
   endfunction

   task automatic offer(input logic [VALUE_BITS-1:0] value, input logic [RADIX_W-1:0] radix);
      int gap;
      gap = send_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_radix <= radix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic offer_random(input int count);
      logic [RADIX_W-1:0] radix;
      repeat (count) begin
         radix = pick_radix();
         offer(pick_value(radix), radix);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_pending != 0) @(posedge clock);
   endtask

   initial begin : sink
      int   stall;
      int   served;
      logic ready_next;
      stall  = 0;
      served = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_asks != served) begin
            served = hold_off_asks;
            stall  = HOLD_OFF_CYCLES;
         end else if (stall == 0 && sink_gaps) begin
            if (rsp_valid && rsp_ready) begin
               stall = pick_gap();
            end else if (!rsp_valid && $urandom_range(15) == 0) begin
               stall = pick_gap();
            end
         end
         if (stall > 0) begin
            ready_next = 1'b0;
            stall--;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
         @(posedge clock);
      end
   end

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer(32'd0, 5'd10);
      offer(32'd0, 5'd0);
      offer(32'd0, 5'd31);
      offer(32'hFFFF_FFFF, 5'd2);
      offer(32'hFFFF_FFFF, 5'd16);
      offer(32'hFFFF_FFFF, 5'd3);
      offer(32'hFFFF_FFFF, 5'd10);
      offer(32'h8000_0000, 5'd2);
      offer(32'd1, 5'd2);
      offer(32'd1, 5'd16);
      offer(32'd15, 5'd16);
      offer(32'd16, 5'd16);
      offer(32'd9, 5'd9);
      offer(32'd24, 5'd5);
      offer(32'd12345, 5'd0);
      offer(32'd12345, 5'd1);
      offer(32'd12345, 5'd17);
      offer(32'hDEAD_BEEF, 5'd31);
      offer(32'h7FFF_FFFF, 5'd8);
      offer(32'd99, 5'd10);
      offer(32'd100, 5'd10);
      offer(32'd35, 5'd15);
      wait_drained();

      send_gaps <= 1'b1;
      sink_gaps <= 1'b1;
      offer_random(120);
      wait_drained();

      send_gaps <= 1'b0;
      sink_gaps <= 1'b0;
      offer_random(90);

      send_gaps     <= 1'b1;
      sink_gaps     <= 1'b1;
      hold_off_asks <= hold_off_asks + 1;
      offer_random(120);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && beats_pending == 0) begin
         $display("** radix_integer_to_ascii_core: PASSED **");
      end else begin
         $display("** radix_integer_to_ascii_core: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("** radix_integer_to_ascii_core: FAILED **");
      $finish;
   end

endmodule
